@@ src/tvfu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tvfu_pkg
// Shared widths, register indexes and pipeline record types for the TSDF
// voxel fusion update core.
// ----------------------------------------------------------------------------
package tvfu_pkg;

	localparam int MEAS_W     = 31;  // measured depth, unsigned Q15.16
	localparam int DEPTH_W    = 32;  // voxel depth, signed Q16.16
	localparam int SDF_W      = 16;  // Q1.15 signed distance
	localparam int WGT_W      = 16;  // integer weight
	localparam int MU_W       = 31;  // truncation distance
	localparam int Q_W        = 15;  // quotient bits of both divides
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;

	localparam logic [MU_W-1:0]  MU_RESET   = 31'd1311;
	localparam logic [WGT_W-1:0] MAXW_RESET = 16'd128;
	localparam logic [SDF_W-1:0] SDF_MIN    = 16'h8000;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_TRUNC_DISTANCE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WEIGHT     = 1'b1;

	// |eta| * 32767 over mu
	typedef struct packed {
		logic                   skip;
		logic                   neg;
		logic [31:0]            wsdf;  // w * old_sdf, two's complement
		logic [SDF_W-1:0]       sdf;
		logic [WGT_W-1:0]       w;
		logic [MU_W+Q_W-1:0]    rem;
		logic [Q_W-1:0]         q;
	} tvfu_d1_t;

	// |num| over w + 1
	typedef struct packed {
		logic                   skip;
		logic                   neg;
		logic [SDF_W-1:0]       sdf;
		logic [WGT_W-1:0]       w;
		logic [WGT_W:0]         dvs;
		logic [31:0]            rem;
		logic [Q_W-1:0]         q;
	} tvfu_d2_t;

	typedef struct packed {
		logic [SDF_W-1:0] sdf;
		logic [WGT_W-1:0] w;
		logic             upd;
	} tvfu_res_t;

endpackage
`default_nettype wire

@@ src/tsdf_voxel_fusion_update_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsdf_voxel_fusion_update_core
// Weighted running-average TSDF update of one voxel per beat.
//
// Input channel: one beat per voxel (depths, view flag, stored sdf/weight),
// taken when in_valid is high and in_stall is low. Output channel: one beat
// per input beat, in order, with the fused or passed-through sdf and weight.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 = trunc
// distance, 1 = max weight) on the clock edge; write only while idle.
//
// Throughput is one voxel per cycle while in_stall is low. The pipeline is
// three prep stages, 15 restoring-divide stages for eta/mu, two stages
// to form the weighted sum, 15 divide stages for the 1/(w+1) average,
// then the output register.
// The output register is backed by a one-beat skid stage: in_stall is a
// register and rises only when a result arrives while the output is stalled;
// the whole pipeline then holds until the skid drains.
// Reset clears all valids and loads trunc distance 1311, max weight 128.
// ----------------------------------------------------------------------------
module tsdf_voxel_fusion_update_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tvfu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [tvfu_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [tvfu_pkg::MEAS_W-1:0]         measured_depth,
	input  wire logic signed [tvfu_pkg::DEPTH_W-1:0] voxel_depth,
	input  wire logic                                in_view,
	input  wire logic signed [tvfu_pkg::SDF_W-1:0]   old_sdf,
	input  wire logic [tvfu_pkg::WGT_W-1:0]          stored_weight,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [tvfu_pkg::SDF_W-1:0]        new_sdf,
	output logic [tvfu_pkg::WGT_W-1:0]               fused_weight,
	output logic                                     updated
);
	import tvfu_pkg::*;

	logic [MU_W-1:0]  mu_q;
	logic [WGT_W-1:0] maxw_q;
	logic             en;

	// stage 1: eta
	logic                vld_s1, view_s1;
	logic [32:0]         eta_s1;
	logic [SDF_W-1:0]    sdf_s1;
	logic [WGT_W-1:0]    w_s1;
	// stage 2: |eta| and skip test
	logic                vld_s2, skip_s2, neg_s2;
	logic [31:0]         abs_s2;
	logic [SDF_W-1:0]    sdf_s2;
	logic [WGT_W-1:0]    w_s2;
	// divide 1 stages, index 0 is stage 3
	logic [Q_W:0]        d1_vld_s;
	tvfu_d1_t            d1_s [0:Q_W];
	tvfu_d1_t            d1_nxt [0:Q_W-1];
	// stage 4: weighted sum
	logic                vld_s4, skip_s4;
	logic [32:0]         num_s4;
	logic [SDF_W-1:0]    sdf_s4;
	logic [WGT_W-1:0]    w_s4;
	// divide 2 stages, index 0 is stage 5
	logic [Q_W:0]        d2_vld_s;
	tvfu_d2_t            d2_s [0:Q_W];
	tvfu_d2_t            d2_nxt [0:Q_W-1];
	// output side
	tvfu_res_t           fin;
	tvfu_res_t           out_q, skid_q;
	logic                out_valid_q, skid_full_q, arrive;

	logic [32:0]         abs_c;
	logic [MU_W-1:0]     a_c;
	logic [32:0]         wprod_c;
	logic [16:0]         e_c;
	logic [32:0]         num_c;
	logic [32:0]         nmag_c;
	logic [16:0]         w1_c;
	logic [SDF_W-1:0]    s_c;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q   <= MU_RESET;
			maxw_q <= MAXW_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TRUNC_DISTANCE: mu_q   <= cfg_data[MU_W-1:0];
				CFG_MAX_WEIGHT:     maxw_q <= cfg_data[WGT_W-1:0];
				default: ;
			endcase
		end
	end

	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;

	// ---------------- valid chain ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s4   <= 1'b0;
			d1_vld_s <= '0;
			d2_vld_s <= '0;
		end else if (en) begin
			vld_s1   <= in_valid;
			vld_s2   <= vld_s1;
			d1_vld_s <= {d1_vld_s[Q_W-1:0], vld_s2};
			vld_s4   <= d1_vld_s[Q_W];
			d2_vld_s <= {d2_vld_s[Q_W-1:0], vld_s4};
		end
	end

	// ---------------- stages 1..3 ----------------
	assign abs_c   = eta_s1[32] ? (33'd0 - eta_s1) : eta_s1;
	assign a_c     = abs_s2[MU_W-1:0];
	assign wprod_c = 33'($signed({1'b0, w_s2}) * $signed(sdf_s2));

	always_ff @(posedge clk) begin
		if (en) begin
			eta_s1  <= {2'b00, measured_depth} - {voxel_depth[DEPTH_W-1], voxel_depth};
			view_s1 <= in_view;
			sdf_s1  <= old_sdf;
			w_s1    <= stored_weight;

			abs_s2  <= abs_c[31:0];
			neg_s2  <= eta_s1[32];
			skip_s2 <= !view_s1 || (abs_c > {2'b00, mu_q}) || (w_s1 == maxw_q);
			sdf_s2  <= sdf_s1;
			w_s2    <= w_s1;

			// |eta| * 32767 as a shift and subtract
			d1_s[0].skip <= skip_s2;
			d1_s[0].neg  <= neg_s2;
			d1_s[0].wsdf <= wprod_c[31:0];
			d1_s[0].sdf  <= sdf_s2;
			d1_s[0].w    <= w_s2;
			d1_s[0].rem  <= {a_c, {Q_W{1'b0}}} - {{Q_W{1'b0}}, a_c};
			d1_s[0].q    <= '0;
		end
	end

	// ---------------- divide 1: one quotient bit per stage ----------------
	// |eta| <= mu, so the quotient always fits in Q_W bits
	for (genvar k = 0; k < Q_W; k++) begin : g_d1
		logic [MU_W+Q_W-1:0] dsh;
		logic                ge;
		assign dsh = {{Q_W{1'b0}}, mu_q} << (Q_W - 1 - k);
		assign ge  = d1_s[k].rem >= dsh;
		always_comb begin
			d1_nxt[k] = d1_s[k];
			if (ge) begin
				d1_nxt[k].rem           = d1_s[k].rem - dsh;
				d1_nxt[k].q[Q_W-1-k]    = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			if (en)
				d1_s[k+1] <= d1_nxt[k];
		end
	end

	// ---------------- stage 4: e and weighted sum ----------------
	// zero mu passes only eta == 0, and e is then 0
	always_comb begin
		if (mu_q == '0)
			e_c = '0;
		else if (d1_s[Q_W].neg)
			e_c = 17'd0 - {2'b00, d1_s[Q_W].q};
		else
			e_c = {2'b00, d1_s[Q_W].q};
	end
	assign num_c  = {d1_s[Q_W].wsdf[31], d1_s[Q_W].wsdf} + {{16{e_c[16]}}, e_c};
	assign nmag_c = num_s4[32] ? (33'd0 - num_s4) : num_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s4  <= num_c;
			skip_s4 <= d1_s[Q_W].skip;
			sdf_s4  <= d1_s[Q_W].sdf;
			w_s4    <= d1_s[Q_W].w;

			d2_s[0].skip <= skip_s4;
			d2_s[0].neg  <= num_s4[32];
			d2_s[0].sdf  <= sdf_s4;
			d2_s[0].w    <= w_s4;
			d2_s[0].dvs  <= {1'b0, w_s4} + 17'd1;
			d2_s[0].rem  <= nmag_c[31:0];
			d2_s[0].q    <= '0;
		end
	end

	// ---------------- divide 2 ----------------
	// |num| < 32768 * (w + 1), so the average also fits in Q_W bits
	for (genvar k = 0; k < Q_W; k++) begin : g_d2
		logic [31:0] dsh;
		logic        ge;
		assign dsh = {15'd0, d2_s[k].dvs} << (Q_W - 1 - k);
		assign ge  = d2_s[k].rem >= dsh;
		always_comb begin
			d2_nxt[k] = d2_s[k];
			if (ge) begin
				d2_nxt[k].rem        = d2_s[k].rem - dsh;
				d2_nxt[k].q[Q_W-1-k] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			if (en)
				d2_s[k+1] <= d2_nxt[k];
		end
	end

	// ---------------- result ----------------
	assign w1_c = {1'b0, d2_s[Q_W].w} + 17'd1;
	assign s_c  = d2_s[Q_W].neg ? (16'd0 - {1'b0, d2_s[Q_W].q}) : {1'b0, d2_s[Q_W].q};

	always_comb begin
		if (d2_s[Q_W].skip) begin
			fin.sdf = d2_s[Q_W].sdf;
			fin.w   = d2_s[Q_W].w;
			fin.upd = 1'b0;
		end else begin
			fin.sdf = s_c;
			fin.w   = (w1_c > {1'b0, maxw_q}) ? maxw_q : w1_c[WGT_W-1:0];
			fin.upd = 1'b1;
		end
	end

	assign arrive = en && d2_vld_s[Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (!out_stall)
				skid_full_q <= 1'b0;
		end else if (arrive) begin
			if (!out_valid_q || !out_stall)
				out_valid_q <= 1'b1;
			else
				skid_full_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (!out_stall)
				out_q <= skid_q;
		end else if (arrive) begin
			if (!out_valid_q || !out_stall)
				out_q <= fin;
			else
				skid_q <= fin;
		end
	end

	assign out_valid    = out_valid_q;
	assign new_sdf      = $signed(out_q.sdf);
	assign fused_weight = out_q.w;
	assign updated      = out_q.upd;

	// ---------------- assertions ----------------
	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_valid_q)
		else $error("skid holds a beat with no beat at the output");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_stall))
		else $error("skid filled while output was not stalled");

	a_sdf_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && updated) |-> (out_q.sdf != SDF_MIN))
		else $error("fused sdf out of range");

	a_wgt_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && updated) |-> (fused_weight <= maxw_q))
		else $error("fused weight above ceiling");

	a_wgt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && updated && (maxw_q != '0)) |-> (fused_weight != '0))
		else $error("fused weight is zero under a nonzero ceiling");

endmodule
`default_nettype wire

@@ bench/tvfu_fusion_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tvfu_fusion_checker
// Watches both channels and the register port of the TSDF fusion core,
// predicts each voxel update and compares results in order, field by field.
// ----------------------------------------------------------------------------
module tvfu_fusion_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tvfu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [tvfu_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	input  wire logic                                in_stall,
	input  wire logic [tvfu_pkg::MEAS_W-1:0]         measured_depth,
	input  wire logic signed [tvfu_pkg::DEPTH_W-1:0] voxel_depth,
	input  wire logic                                in_view,
	input  wire logic signed [tvfu_pkg::SDF_W-1:0]   old_sdf,
	input  wire logic [tvfu_pkg::WGT_W-1:0]          stored_weight,
	input  wire logic                                out_valid,
	input  wire logic                                out_stall,
	input  wire logic signed [tvfu_pkg::SDF_W-1:0]   new_sdf,
	input  wire logic [tvfu_pkg::WGT_W-1:0]          fused_weight,
	input  wire logic                                updated,
	output int                                       n_fail,
	output int                                       n_pending,
	output int                                       n_checked,
	output int                                       n_fused
);
	import tvfu_pkg::*;

	localparam longint SDF_ONE = 32767;

	logic [MU_W-1:0]  band_mu;
	logic [WGT_W-1:0] weight_cap;
	tvfu_res_t        fused_q[$];

	function automatic tvfu_res_t fuse_voxel(input logic [MEAS_W-1:0] meas,
			input logic signed [DEPTH_W-1:0] vdep, input logic view,
			input logic signed [SDF_W-1:0] sdf, input logic [WGT_W-1:0] w);
		longint    eta;
		longint    mag;
		longint    e;
		longint    s;
		longint    nw;
		tvfu_res_t r;
		eta = longint'(meas) - longint'(vdep);
		mag = (eta < 0) ? -eta : eta;
		if (!view || mag > longint'(band_mu) || w == weight_cap) begin
			r.sdf = sdf;
			r.w   = w;
			r.upd = 1'b0;
			return r;
		end
		// measurement term, truncated toward zero, capped at +1.0
		e = 0;
		if (band_mu != '0)
			e = (eta * SDF_ONE) / longint'(band_mu);
		if (e > SDF_ONE)
			e = SDF_ONE;
		s = (longint'(w) * longint'(sdf) + e) / (longint'(w) + 1);
		if (s > SDF_ONE)
			s = SDF_ONE;
		if (s < -SDF_ONE)
			s = -SDF_ONE;
		nw = longint'(w) + 1;
		if (nw > longint'(weight_cap))
			nw = longint'(weight_cap);
		r.sdf = s[SDF_W-1:0];
		r.w   = nw[WGT_W-1:0];
		r.upd = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tvfu_res_t want;
		int        bad;
		if (!arst_n) begin
			band_mu    <= MU_RESET;
			weight_cap <= MAXW_RESET;
			fused_q.delete();
			n_fail     <= 0;
			n_pending  <= 0;
			n_checked  <= 0;
			n_fused    <= 0;
		end else begin
			bad = 0;
			if (cfg_we) begin
				if (cfg_index == CFG_TRUNC_DISTANCE)
					band_mu <= cfg_data[MU_W-1:0];
				else if (cfg_index == CFG_MAX_WEIGHT)
					weight_cap <= cfg_data[WGT_W-1:0];
			end
			if (in_valid && !in_stall)
				fused_q.insert(fused_q.size(), fuse_voxel(measured_depth, voxel_depth,
					in_view, old_sdf, stored_weight));
			if (out_valid && !out_stall) begin
				if (fused_q.size() == 0) begin
					$display("%0t: result beat with nothing expected: sdf %0d weight %0d upd %0b",
						$time, new_sdf, fused_weight, updated);
					bad++;
				end else begin
					want = fused_q.pop_front();
					if (new_sdf !== want.sdf) begin
						$display("%0t: new_sdf expected %0d actual %0d", $time,
							$signed(want.sdf), new_sdf);
						bad++;
					end
					if (fused_weight !== want.w) begin
						$display("%0t: fused_weight expected %0d actual %0d", $time,
							want.w, fused_weight);
						bad++;
					end
					if (updated !== want.upd) begin
						$display("%0t: updated expected %0b actual %0b", $time,
							want.upd, updated);
						bad++;
					end
					n_checked <= n_checked + 1;
					if (want.upd)
						n_fused <= n_fused + 1;
				end
			end
			n_fail    <= n_fail + bad;
			n_pending <= fused_q.size();
		end
	end

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the TSDF voxel fusion core: directed corner
// voxels, then random phases over several register settings with bursty
// idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
	import tvfu_pkg::*;

	localparam int     LIMIT       = 400000;
	localparam int     N_PHASES    = 6;
	localparam int     PHASE_BEATS = 158;
	localparam int     HOLD_CYCLES = 300;
	localparam longint MEAS_MAX    = 64'h7fff_ffff;

	typedef struct {
		logic [MEAS_W-1:0]         meas;
		logic signed [DEPTH_W-1:0] vdep;
		logic                      view;
		logic signed [SDF_W-1:0]   sdf;
		logic [WGT_W-1:0]          w;
	} voxel_t;

	logic                      clk            = 1'b0;
	logic                      arst_n         = 1'b0;
	logic                      cfg_we         = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index      = CFG_TRUNC_DISTANCE;
	logic [CFG_DATA_W-1:0]     cfg_data       = '0;
	logic                      in_valid       = 1'b0;
	logic                      in_stall;
	logic [MEAS_W-1:0]         measured_depth = '0;
	logic signed [DEPTH_W-1:0] voxel_depth    = '0;
	logic                      in_view        = 1'b0;
	logic signed [SDF_W-1:0]   old_sdf        = '0;
	logic [WGT_W-1:0]          stored_weight  = '0;
	logic                      out_valid;
	logic                      out_stall      = 1'b0;
	logic signed [SDF_W-1:0]   new_sdf;
	logic [WGT_W-1:0]          fused_weight;
	logic                      updated;

	int n_fail, n_pending, n_checked, n_fused;
	int cycles = 0;
	bit tx_idle_on   = 1'b1;
	bit rx_idle_on   = 1'b1;
	bit hold_pending = 1'b0;

	tsdf_voxel_fusion_update_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.measured_depth(measured_depth), .voxel_depth(voxel_depth), .in_view(in_view),
		.old_sdf(old_sdf), .stored_weight(stored_weight),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_sdf(new_sdf), .fused_weight(fused_weight), .updated(updated)
	);

	tvfu_fusion_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.measured_depth(measured_depth), .voxel_depth(voxel_depth), .in_view(in_view),
		.old_sdf(old_sdf), .stored_weight(stored_weight),
		.out_valid(out_valid), .out_stall(out_stall),
		.new_sdf(new_sdf), .fused_weight(fused_weight), .updated(updated),
		.n_fail(n_fail), .n_pending(n_pending), .n_checked(n_checked), .n_fused(n_fused)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, n_pending);
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin : sink
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				if (stall_left == 0 && rx_idle_on && $urandom_range(5, 0) == 0)
					stall_left = $urandom_range(16, 1);
				if (stall_left > 0) begin
					out_stall <= 1'b1;
					stall_left--;
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// valid stays high across back-to-back beats; it only drops for a gap
	task automatic send_voxel(input voxel_t v);
		if (tx_idle_on && $urandom_range(3, 0) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(16, 1)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		measured_depth <= v.meas;
		voxel_depth    <= v.vdep;
		in_view        <= v.view;
		old_sdf        <= v.sdf;
		stored_weight  <= v.w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_fields(input logic [MEAS_W-1:0] meas,
			input logic signed [DEPTH_W-1:0] vdep, input logic view,
			input logic signed [SDF_W-1:0] sdf, input logic [WGT_W-1:0] w);
		voxel_t v;
		v.meas = meas;
		v.vdep = vdep;
		v.view = view;
		v.sdf  = sdf;
		v.w    = w;
		send_voxel(v);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
	endtask

	// mostly in-band fusable voxels with random content, some band and
	// ceiling edges, some fully random noise
	function automatic voxel_t make_voxel(input longint mu, input longint maxw);
		voxel_t v;
		longint eta;
		longint hi;
		int     pick;
		pick   = $urandom_range(9, 0);
		v.view = 1'b1;
		v.sdf  = SDF_W'($urandom);
		if ($urandom_range(15, 0) == 0)
			v.sdf = SDF_MIN;
		if (pick >= 8) begin
			v.meas = MEAS_W'($urandom);
			v.vdep = $urandom;
			v.view = 1'($urandom_range(1, 0));
			v.w    = WGT_W'($urandom);
			return v;
		end
		if (pick == 7) begin
			eta = mu + $urandom_range(1, 0);
			if (eta > MEAS_MAX)
				eta = MEAS_MAX;
			hi = maxw + $urandom_range(1, 0) - $urandom_range(1, 0);
			if (hi > 65535)
				hi = 65535;
			v.w    = hi[WGT_W-1:0];
			v.view = 1'($urandom_range(1, 0));
		end else begin
			if ($urandom_range(3, 0) == 0)
				eta = longint'($urandom_range(32'((mu < 64) ? mu : 64), 0));
			else
				eta = longint'($urandom_range(32'(mu), 0));
			hi = maxw - 1;
			if ($urandom_range(1, 0) == 0 && hi > 15)
				hi = 15;
			v.w = WGT_W'($urandom_range(32'(hi), 0));
		end
		if ($urandom_range(1, 0) == 0)
			eta = -eta;
		hi     = (eta >= 0) ? MEAS_MAX : MEAS_MAX + eta;
		v.meas = MEAS_W'($urandom_range(32'(hi), 0));
		hi     = longint'(v.meas) - eta;
		v.vdep = hi[DEPTH_W-1:0];
		return v;
	endfunction

	initial begin : stimulus
		longint mu_set[N_PHASES];
		longint maxw_set[N_PHASES];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: band 1311, ceiling 128
		send_fields(1000000, 1000000, 1'b0, 100, 3);
		send_fields(1000000 + 1311, 1000000, 1'b1, 0, 0);
		send_fields(1000000 - 1311, 1000000, 1'b1, 0, 0);
		send_fields(1000000 + 1312, 1000000, 1'b1, 0, 0);
		send_fields(1000000 - 1312, 1000000, 1'b1, 5, 2);
		send_fields(500, 500, 1'b1, 1234, 128);
		send_fields(500, 499, 1'b1, -1234, 127);
		send_fields(500, 501, 1'b1, 7, 9);
		send_fields(0, 0, 1'b1, SDF_MIN, 0);
		send_fields(20, 20, 1'b1, SDF_MIN, 5);
		send_fields(MEAS_W'(MEAS_MAX), DEPTH_W'(MEAS_MAX), 1'b1, 32767, 65535);
		send_fields(2000 + 1311, 2000, 1'b1, 32767, 65535);
		send_fields(2000 - 1311, 2000, 1'b1, SDF_MIN, 65535);
		send_fields(0, 32'sh8000_0000, 1'b1, 0, 0);
		send_fields(MEAS_W'(MEAS_MAX), 32'sh8000_0000, 1'b1, 0, 0);
		send_fields(0, 32'sh7fff_ffff, 1'b1, 0, 0);
		drain();

		write_reg(CFG_TRUNC_DISTANCE, 31'h7fff_ffff);
		write_reg(CFG_MAX_WEIGHT, 31'd65535);
		send_fields(MEAS_W'(MEAS_MAX), 0, 1'b1, 100, 1);
		send_fields(0, 32'sh7fff_ffff, 1'b1, -100, 1);
		send_fields(0, 32'sh8000_0000, 1'b1, 0, 0);
		send_fields(777, 777, 1'b1, 3, 65535);
		send_fields(777, 776, 1'b1, 3, 65534);
		drain();

		write_reg(CFG_TRUNC_DISTANCE, 31'd1);
		write_reg(CFG_MAX_WEIGHT, 31'd1);
		send_fields(10, 9, 1'b1, 0, 0);
		send_fields(10, 10, 1'b1, 0, 1);
		send_fields(10, 11, 1'b1, 0, 2);
		send_fields(10, 12, 1'b1, 0, 0);

		mu_set[0] = longint'($urandom_range(4096, 64));
		maxw_set[0] = longint'($urandom_range(64, 2));
		mu_set[1] = 1;                             maxw_set[1] = 1;
		mu_set[2] = MEAS_MAX;                      maxw_set[2] = 65535;
		mu_set[3] = longint'($urandom_range(32'h7fff_ffff, 1));
		maxw_set[3] = longint'($urandom_range(65535, 1));
		mu_set[4] = 65536;
		maxw_set[4] = longint'($urandom_range(300, 2));
		mu_set[5] = MU_RESET;                      maxw_set[5] = MAXW_RESET;

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			write_reg(CFG_TRUNC_DISTANCE, mu_set[p][CFG_DATA_W-1:0]);
			write_reg(CFG_MAX_WEIGHT, maxw_set[p][CFG_DATA_W-1:0]);
			tx_idle_on = (p != 2 && p != N_PHASES - 1);
			rx_idle_on = (p != N_PHASES - 1);
			// back the pipe up until the input stalls
			if (p == 2)
				hold_pending = 1'b1;
			repeat (PHASE_BEATS)
				send_voxel(make_voxel(mu_set[p], maxw_set[p]));
		end

		drain();
		repeat (60) @(posedge clk);
		$display("checked %0d result beats: %0d fused, %0d passed through",
			n_checked, n_fused, n_checked - n_fused);
		$display("covered %0d register settings, bursty idling and a %0d-cycle output hold",
			N_PHASES + 3, HOLD_CYCLES);
		if (n_fail == 0 && n_pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches, %0d results outstanding", n_fail, n_pending);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
